### rtl/core/lpe_pkg.sv
// shared types and constants for the legendre polynomial evaluator
`default_nettype none

package lpe_pkg;

  // width of the order register
  localparam int ORDER_W = 5;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_AX   = 6'b000010,
    ST_BP   = 6'b000100,
    ST_TC   = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_DONE = 6'b100000
  } lpe_state_t;

  typedef enum logic [1:0] {
    MUL_AX = 2'd0,
    MUL_BP = 2'd1,
    MUL_TC = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     zero_order;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     take_t;
    logic     take_b;
    logic     update;
    logic     capture;
  } dp_ctl_t;

endpackage

`default_nettype wire

### rtl/core/legendre_polynomial_eval.sv
// top level of the legendre polynomial evaluator (bonnet recurrence)
//
// channel   signals                                   direction
// input     in_valid, in_ready, x_value               in
// output    out_valid, out_ready, poly_value,         out
//           saturated
// config    cfg_valid, cfg_ready, poly_order          in
//
// orders 0 and 1: the accepted item goes straight to done, with no recurrence step.
// order n >= 2: the recurrence runs from P1 up to Pn, with three passes of the single
// shared multiplier per recurrence step (a*x, b*prev, t*cur).
// one item is in flight at a time; in_ready is high only while idle.
// a finished result sits in the output register until taken, and the next
// item may be accepted meanwhile; that item then waits in done until the slot frees.
// reset clears the order register to 0 and empties the output register.
`default_nettype none

module legendre_polynomial_eval #(
  parameter int MAX_ORDER = 31,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [FRAC_BITS+1:0] x_value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed      [FRAC_BITS+1:0] poly_value,
  output logic                             saturated,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [lpe_pkg::ORDER_W-1:0] poly_order
);
  import lpe_pkg::*;

  localparam int CW = $clog2(MAX_ORDER + 1);

  logic [ORDER_W-1:0]   order_cfg;
  logic [CW-1:0]        coef_addr;
  logic [FRAC_BITS+1:0] coef_a;
  logic [FRAC_BITS+1:0] coef_b;
  dp_ctl_t              ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_cfg <= '0;
    end else if (cfg_valid) begin
      order_cfg <= poly_order;
    end
  end

  lpe_ctrl #(
    .MAX_ORDER (MAX_ORDER)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .order_cfg (order_cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .coef_addr (coef_addr),
    .ctl       (ctl)
  );

  lpe_coef #(
    .MAX_ORDER (MAX_ORDER),
    .FRAC_BITS (FRAC_BITS)
  ) u_coef (
    .addr   (coef_addr),
    .coef_a (coef_a),
    .coef_b (coef_b)
  );

  lpe_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .ctl        (ctl),
    .x_value    (x_value),
    .coef_a     (coef_a),
    .coef_b     (coef_b),
    .poly_value (poly_value),
    .saturated  (saturated)
  );

endmodule

`default_nettype wire

### rtl/core/lpe_coef.sv
// recurrence coefficient table (2i+1)/(i+1) and i/(i+1) in unsigned q2.f
`default_nettype none

module lpe_coef #(
  parameter int MAX_ORDER = 31,
  parameter int FRAC_BITS = 16,
  parameter int CW        = $clog2(MAX_ORDER + 1)
) (
  input  wire logic [CW-1:0]          addr,
  output logic      [FRAC_BITS+1:0]   coef_a,
  output logic      [FRAC_BITS+1:0]   coef_b
);

  logic [FRAC_BITS+1:0] a_tab [MAX_ORDER+1];
  logic [FRAC_BITS+1:0] b_tab [MAX_ORDER+1];

  for (genvar g = 0; g <= MAX_ORDER; g++) begin : g_tab
    localparam longint unsigned DEN   = longint'(g) + 1;
    localparam longint unsigned A_NUM = longint'(2 * g + 1) << FRAC_BITS;
    localparam longint unsigned B_NUM = longint'(g) << FRAC_BITS;
    localparam longint unsigned A_VAL = (A_NUM + DEN / 2) / DEN;
    localparam longint unsigned B_VAL = (B_NUM + DEN / 2) / DEN;
    assign a_tab[g] = A_VAL[FRAC_BITS+1:0];
    assign b_tab[g] = B_VAL[FRAC_BITS+1:0];
  end

  assign coef_a = a_tab[addr];
  assign coef_b = b_tab[addr];

endmodule

`default_nettype wire

### rtl/core/lpe_datapath.sv
// shared multiplier, rounding, clamp and recurrence registers
`default_nettype none

module lpe_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire lpe_pkg::dp_ctl_t            ctl,
  input  wire logic signed [FRAC_BITS+1:0] x_value,
  input  wire logic        [FRAC_BITS+1:0] coef_a,
  input  wire logic        [FRAC_BITS+1:0] coef_b,
  output logic signed      [FRAC_BITS+1:0] poly_value,
  output logic                             saturated
);
  import lpe_pkg::*;

  localparam int XW = FRAC_BITS + 2;
  localparam int AW = FRAC_BITS + 3;
  localparam int PW = 2 * FRAC_BITS + 5;
  localparam int RW = FRAC_BITS + 4;

  localparam logic signed [XW-1:0] ONE_X = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic signed [RW-1:0] ONE_R = {4'b0001, {FRAC_BITS{1'b0}}};
  localparam logic [PW-1:0] HALF = {{(PW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  logic signed [XW-1:0] x_reg;
  logic signed [XW-1:0] prev;
  logic signed [XW-1:0] cur;
  logic signed [AW-1:0] t_reg;
  logic signed [RW-1:0] b_term;
  logic signed [PW-1:0] prod;
  logic                 flag;

  logic signed [XW-1:0] x_clamped;
  logic signed [AW-1:0] op_a;
  logic signed [XW-1:0] op_b;
  logic signed [PW-1:0] prod_next;
  logic signed [RW-1:0] rnd_now;
  logic signed [RW-1:0] diff;
  logic                 clamp_hi;
  logic                 clamp_lo;
  logic signed [XW-1:0] nxt;

  // shift right by frac bits, round to nearest, ties away from zero
  function automatic logic signed [RW-1:0] rnd_q(input logic signed [PW-1:0] p);
    logic [PW-1:0] mag;
    logic [PW-1:0] sh;
    mag = p[PW-1] ? PW'(-p) : PW'(p);
    sh  = (mag + HALF) >> FRAC_BITS;
    rnd_q = p[PW-1] ? -sh[RW-1:0] : sh[RW-1:0];
  endfunction

  always_comb begin
    if (x_value > ONE_X) begin
      x_clamped = ONE_X;
    end else if (x_value < -ONE_X) begin
      x_clamped = -ONE_X;
    end else begin
      x_clamped = x_value;
    end
  end

  always_comb begin
    case (ctl.mul_sel)
      MUL_AX: begin
        op_a = {1'b0, coef_a};
        op_b = x_reg;
      end
      MUL_BP: begin
        op_a = {1'b0, coef_b};
        op_b = prev;
      end
      MUL_TC: begin
        op_a = t_reg;
        op_b = cur;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_next = op_a * op_b;
  assign rnd_now   = rnd_q(prod);
  assign diff      = rnd_now - b_term;
  assign clamp_hi  = diff > ONE_R;
  assign clamp_lo  = diff < -ONE_R;

  always_comb begin
    if (clamp_hi) begin
      nxt = ONE_X;
    end else if (clamp_lo) begin
      nxt = -ONE_X;
    end else begin
      nxt = diff[XW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= prod_next;
    end
    if (ctl.load) begin
      x_reg <= x_clamped;
      prev  <= ONE_X;
      cur   <= ctl.zero_order ? ONE_X : x_clamped;
      flag  <= 1'b0;
    end
    if (ctl.take_t) begin
      t_reg <= rnd_now[AW-1:0];
    end
    if (ctl.take_b) begin
      b_term <= rnd_now;
    end
    if (ctl.update) begin
      prev <= cur;
      cur  <= nxt;
      if (clamp_hi || clamp_lo) begin
        flag <= 1'b1;
      end
    end
    if (ctl.capture) begin
      poly_value <= cur;
      saturated  <= flag;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lpe_ctrl.sv
// sequencer: step counter, phase state machine and output handshake
`default_nettype none

module lpe_ctrl #(
  parameter int MAX_ORDER = 31,
  parameter int CW        = $clog2(MAX_ORDER + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [lpe_pkg::ORDER_W-1:0] order_cfg,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [CW-1:0]               coef_addr,
  output lpe_pkg::dp_ctl_t                 ctl
);
  import lpe_pkg::*;

  localparam int MW = (CW > ORDER_W) ? CW : ORDER_W;
  localparam logic [MW-1:0] MAX_M = MW'(MAX_ORDER);

  lpe_state_t    state;
  lpe_state_t    state_next;
  logic [CW-1:0] step;
  logic [CW-1:0] step_next;
  logic [CW-1:0] step_inc;
  logic [MW-1:0] ord_ext;
  logic [CW-1:0] n_eff;

  assign ord_ext  = MW'(order_cfg);
  assign n_eff    = (ord_ext > MAX_M) ? MAX_M[CW-1:0] : ord_ext[CW-1:0];
  assign step_inc = step + 1'b1;

  // the update cycle already fetches the next step's coefficients
  assign coef_addr = (state == ST_UPD) ? step_inc : step;

  always_comb begin
    state_next = state;
    step_next  = step;
    in_ready   = 1'b0;
    ctl        = '0;
    ctl.mul_sel = MUL_AX;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load       = 1'b1;
          ctl.zero_order = (n_eff == '0);
          if (n_eff <= CW'(1)) begin
            state_next = ST_DONE;
          end else begin
            step_next  = CW'(1);
            state_next = ST_AX;
          end
        end
      end
      ST_AX: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_AX;
        state_next  = ST_BP;
      end
      ST_BP: begin
        ctl.take_t  = 1'b1;
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_BP;
        state_next  = ST_TC;
      end
      ST_TC: begin
        ctl.take_b  = 1'b1;
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_TC;
        state_next  = ST_UPD;
      end
      ST_UPD: begin
        ctl.update = 1'b1;
        if (step_inc == n_eff) begin
          state_next = ST_DONE;
        end else begin
          step_next   = step_inc;
          ctl.mul_en  = 1'b1;
          ctl.mul_sel = MUL_AX;
          state_next  = ST_BP;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          ctl.capture = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (ctl.capture) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/lpe_checker.sv
// port-level checks for the legendre polynomial evaluator, bound to the top
`default_nettype none

module lpe_checker #(
  parameter int FRAC_BITS = 16
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic signed [FRAC_BITS+1:0] x_value,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic signed [FRAC_BITS+1:0] poly_value,
  input wire logic                        saturated,
  input wire logic                        cfg_valid,
  input wire logic                        cfg_ready
);

  localparam logic signed [FRAC_BITS+1:0] ONE_X = {2'b01, {FRAC_BITS{1'b0}}};

  // a waiting result must hold until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(poly_value) && $stable(saturated))
    else $error("result changed while stalled");

  // results never leave the clamped range
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (poly_value <= ONE_X) && (poly_value >= -ONE_X))
    else $error("poly_value outside [-1, 1]");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high in the cycle after an accepted item");

  // a waiting input item holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(x_value))
    else $error("input item changed while waiting");

  // config channel is always open
  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind legendre_polynomial_eval lpe_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_lpe_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .x_value    (x_value),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .poly_value (poly_value),
  .saturated  (saturated),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

`default_nettype wire
